// ----- rtl/core/pts_pkg.sv -----
package pts_pkg;

  localparam int unsigned TASK_SLOTS = 16;
  localparam int unsigned IDX_W      = $clog2(TASK_SLOTS);
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned SLICE_W    = 8;
  localparam int unsigned CNT_W      = 9;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
    logic [SLICE_W-1:0] slice;
    logic              runnable;
  } pts_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] current_slot;
    logic              switched;
    logic [CNT_W-1:0]  current_count;
    logic              refilled;
  } pts_out_t;

  // One task table entry as it is kept in the memory.
  typedef struct packed {
    logic              running;
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  count;
  } pts_entry_t;

endpackage

// ----- rtl/core/priority_timeslice_scheduler_top.sv -----
// Load item: busy through write, read back current task and report; the result
// strobe follows in the next cycle, when a new item can already be accepted.
// Tick item: the current counter is read and decremented when a task runs and it stays nonzero;
// otherwise a scan of slots TASK_SLOTS-1 down to 1 follows, and a refill pass if all counters are spent.
// One item at a time; the memory's single read port and the slot-by-slot pass set this.
// Results are a one-cycle strobe on out_valid; the receiver cannot stall.
// Synchronous active-low reset clears the valid bits, so the whole table reads as zero.
module priority_timeslice_scheduler_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pts_pkg::pts_in_t  in_item,
  output logic              out_valid,
  output pts_pkg::pts_out_t out_result
);

  localparam logic [3:0] ST_IDLE        = 4'd0;
  localparam logic [3:0] ST_LOAD        = 4'd1;
  localparam logic [3:0] ST_RPT_RD      = 4'd2;
  localparam logic [3:0] ST_RPT         = 4'd3;
  localparam logic [3:0] ST_CUR_RD      = 4'd4;
  localparam logic [3:0] ST_DEC         = 4'd5;
  localparam logic [3:0] ST_SCAN        = 4'd6;
  localparam logic [3:0] ST_SCAN_LAST   = 4'd7;
  localparam logic [3:0] ST_REFILL      = 4'd8;
  localparam logic [3:0] ST_REFILL_LAST = 4'd9;

  localparam int unsigned IW = pts_pkg::IDX_W;
  localparam int unsigned CW = pts_pkg::CNT_W;

  logic [3:0]              state_r;
  pts_pkg::pts_in_t        item_r;
  logic [IW-1:0]           cur_r;
  logic [IW-1:0]           idx_r;
  logic [IW-1:0]           rd_idx_r;
  logic                    cmp_en_r;
  logic                    found_r;
  logic [CW-1:0]           best_r;
  logic [IW-1:0]           pick_r;
  logic                    refill_r;
  logic                    out_valid_r;
  pts_pkg::pts_out_t       out_r;

  // Task table memory with a valid bit per entry; an unwritten entry reads as zero.
  pts_pkg::pts_entry_t     mem [pts_pkg::TASK_SLOTS];
  logic [pts_pkg::TASK_SLOTS-1:0] valid_r;
  pts_pkg::pts_entry_t     rdata_r;
  logic                    rd_ok_r;

  logic [IW-1:0]           rd_addr;
  logic                    we;
  logic [IW-1:0]           waddr;
  pts_pkg::pts_entry_t     wdata;
  pts_pkg::pts_entry_t     rd_ent;
  logic                    refill_mode;
  logic [CW-1:0]           new_cnt;
  logic [CW-1:0]           cand;
  logic [CW-1:0]           dec_cnt;
  logic                    found_nxt;
  logic [CW-1:0]           best_nxt;
  logic [IW-1:0]           pick_nxt;
  logic [IW-1:0]           fin_slot;
  logic [CW-1:0]           fin_cnt;
  logic                    load_in_range;
  logic                    need_refill;
  logic                    found_clr;
  logic                    res_fire;

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  always_comb begin
    rd_ent      = rd_ok_r ? rdata_r : '0;
    refill_mode = (state_r == ST_REFILL) || (state_r == ST_REFILL_LAST);
    new_cnt     = (rd_ent.count >> 1) + CW'(rd_ent.prio);
    cand        = refill_mode ? new_cnt : rd_ent.count;
    dec_cnt     = (rd_ent.count != '0) ? rd_ent.count - CW'(1) : '0;

    // Running maximum; a strictly larger counter wins, so ties keep the higher slot.
    found_nxt = found_r;
    best_nxt  = best_r;
    pick_nxt  = pick_r;
    if (cmp_en_r && rd_ent.running && (!found_r || cand > best_r)) begin
      found_nxt = 1'b1;
      best_nxt  = cand;
      pick_nxt  = rd_idx_r;
    end
    fin_slot = found_nxt ? pick_nxt : '0;
    fin_cnt  = found_nxt ? best_nxt : '0;

    need_refill = found_nxt && (best_nxt == '0);
    found_clr   = ((state_r == ST_IDLE) && start) ||
                  ((state_r == ST_SCAN_LAST) && need_refill);
    res_fire    = (state_r == ST_RPT) ||
                  ((state_r == ST_DEC) && (dec_cnt != '0)) ||
                  ((state_r == ST_SCAN_LAST) && !need_refill) ||
                  (state_r == ST_REFILL_LAST);

    load_in_range = 32'(item_r.slot) < 32'(pts_pkg::TASK_SLOTS);
    rd_addr = ((state_r == ST_CUR_RD) || (state_r == ST_RPT_RD)) ? cur_r : idx_r;

    we    = 1'b0;
    waddr = rd_idx_r;
    wdata = rd_ent;
    unique case (state_r)
      ST_LOAD: begin
        we            = load_in_range;
        waddr         = IW'(item_r.slot);
        wdata.running = item_r.runnable;
        wdata.prio    = item_r.prio;
        wdata.count   = CW'(item_r.slice);
      end
      ST_DEC: begin
        we          = 1'b1;
        waddr       = cur_r;
        wdata.count = dec_cnt;
      end
      ST_REFILL, ST_REFILL_LAST: begin
        we          = cmp_en_r;
        wdata.count = new_cnt;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      valid_r     <= '0;
      rd_ok_r     <= 1'b0;
      cmp_en_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ok_r     <= valid_r[rd_addr];
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      cmp_en_r    <= (state_r == ST_SCAN) || (state_r == ST_REFILL);
      rd_idx_r    <= idx_r;
      found_r     <= found_clr ? 1'b0 : found_nxt;
      best_r      <= best_nxt;
      pick_r      <= pick_nxt;
      out_valid_r <= res_fire;

      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            item_r   <= in_item;
            refill_r <= 1'b0;
            idx_r    <= IW'(pts_pkg::TASK_SLOTS - 1);
            if (in_item.func == pts_pkg::FUNC_LOAD) begin
              state_r <= ST_LOAD;
            end else if (cur_r == '0) begin
              state_r <= ST_SCAN;
            end else begin
              state_r <= ST_CUR_RD;
            end
          end
        end
        ST_LOAD: begin
          state_r <= ST_RPT_RD;
        end
        ST_RPT_RD: begin
          state_r <= ST_RPT;
        end
        ST_RPT: begin
          out_r.current_slot   <= pts_pkg::SLOT_W'(cur_r);
          out_r.switched       <= 1'b0;
          out_r.current_count  <= (cur_r == '0) ? '0 : rd_ent.count;
          out_r.refilled       <= 1'b0;
          state_r              <= ST_IDLE;
        end
        ST_CUR_RD: begin
          state_r <= ST_DEC;
        end
        ST_DEC: begin
          if (dec_cnt != '0) begin
            out_r.current_slot  <= pts_pkg::SLOT_W'(cur_r);
            out_r.switched      <= 1'b0;
            out_r.current_count <= dec_cnt;
            out_r.refilled      <= 1'b0;
            state_r             <= ST_IDLE;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN, ST_REFILL: begin
          idx_r <= idx_r - IW'(1);
          if (idx_r == IW'(1)) begin
            state_r <= (state_r == ST_SCAN) ? ST_SCAN_LAST : ST_REFILL_LAST;
          end
        end
        ST_SCAN_LAST: begin
          if (need_refill) begin
            // Every running counter is spent: recompute all counters and rescan
            // in the same pass.
            refill_r <= 1'b1;
            idx_r    <= IW'(pts_pkg::TASK_SLOTS - 1);
            state_r  <= ST_REFILL;
          end else begin
            cur_r               <= fin_slot;
            out_r.current_slot  <= pts_pkg::SLOT_W'(fin_slot);
            out_r.switched      <= (fin_slot != cur_r);
            out_r.current_count <= fin_cnt;
            out_r.refilled      <= refill_r;
            state_r             <= ST_IDLE;
          end
        end
        ST_REFILL_LAST: begin
          cur_r               <= fin_slot;
          out_r.current_slot  <= pts_pkg::SLOT_W'(fin_slot);
          out_r.switched      <= (fin_slot != cur_r);
          out_r.current_count <= fin_cnt;
          out_r.refilled      <= refill_r;
          state_r             <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/pts_checker.sv -----
module pts_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input pts_pkg::pts_out_t out_result
);

  // An accepted transfer always keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // Every item that finishes delivers its result as busy drops.
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("busy dropped without a result");

  // The idle task always reports a zero count.
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.current_slot == '0) |-> (out_result.current_count == '0))
    else $error("idle slot reported a nonzero count");

  // A refill happens only when a running task exists, so one is then chosen.
  a_refill_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.refilled) |-> (out_result.current_slot != '0))
    else $error("refill ended on the idle slot");

endmodule

bind priority_timeslice_scheduler_top pts_checker u_pts_checker (.*);

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1680;
  localparam int TAIL_CYCLES  = 40;

  typedef struct {
    pts_pkg::pts_in_t  item;
    bit                typed;
    pts_pkg::pts_out_t res;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  pts_pkg::pts_in_t  in_item;
  logic              out_valid;
  pts_pkg::pts_out_t out_result;

  // Shadow copy of the task table kept by the predictor.
  logic [pts_pkg::CNT_W-1:0]  shadow_count [pts_pkg::TASK_SLOTS];
  logic [pts_pkg::PRIO_W-1:0] shadow_prio  [pts_pkg::TASK_SLOTS];
  logic                       shadow_run   [pts_pkg::TASK_SLOTS];
  logic [pts_pkg::SLOT_W-1:0] shadow_cur;

  pts_pkg::pts_out_t pending_results[$];
  stim_row_t         stim_table[$];
  int                mismatch_cnt;
  int                quiet_cycles;

  priority_timeslice_scheduler_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_result(out_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Best running slot, scanning from the top; ties keep the higher slot.
  function automatic void scan_best(output logic [pts_pkg::SLOT_W-1:0] pick,
                                    output logic [pts_pkg::CNT_W-1:0] best,
                                    output bit found);
    pick  = '0;
    best  = '0;
    found = 1'b0;
    for (int i = pts_pkg::TASK_SLOTS - 1; i >= 1; i--) begin
      if (shadow_run[i] && (!found || shadow_count[i] > best)) begin
        found = 1'b1;
        best  = shadow_count[i];
        pick  = pts_pkg::SLOT_W'(i);
      end
    end
  endfunction

  function automatic bit reschedule();
    logic [pts_pkg::SLOT_W-1:0] pick;
    logic [pts_pkg::CNT_W-1:0]  best;
    bit                         found;
    bit                         refill;
    refill = 1'b0;
    scan_best(pick, best, found);
    if (found && best == '0) begin
      for (int i = 1; i < pts_pkg::TASK_SLOTS; i++)
        shadow_count[i] = (shadow_count[i] >> 1) + pts_pkg::CNT_W'(shadow_prio[i]);
      refill = 1'b1;
      scan_best(pick, best, found);
    end
    shadow_cur = found ? pick : '0;
    return refill;
  endfunction

  function automatic pts_pkg::pts_out_t predict_schedule(input pts_pkg::pts_in_t it);
    pts_pkg::pts_out_t          res;
    logic [pts_pkg::SLOT_W-1:0] prev;
    bit                         refill;
    prev   = shadow_cur;
    refill = 1'b0;
    if (it.func == pts_pkg::FUNC_LOAD) begin
      shadow_prio[it.slot]  = it.prio;
      shadow_count[it.slot] = pts_pkg::CNT_W'(it.slice);
      shadow_run[it.slot]   = it.runnable;
    end else if (shadow_cur == '0) begin
      refill = reschedule();
    end else begin
      if (shadow_count[shadow_cur] != '0)
        shadow_count[shadow_cur] = shadow_count[shadow_cur] - 1'b1;
      if (shadow_count[shadow_cur] == '0)
        refill = reschedule();
    end
    res.current_slot  = shadow_cur;
    res.switched      = (shadow_cur != prev);
    res.current_count = (shadow_cur == '0) ? '0 : shadow_count[shadow_cur];
    res.refilled      = refill;
    return res;
  endfunction

  function automatic pts_pkg::pts_in_t load_cmd(input int s, input int p, input int sl,
                                                input bit r);
    pts_pkg::pts_in_t it;
    it.func     = pts_pkg::FUNC_LOAD;
    it.slot     = pts_pkg::SLOT_W'(s);
    it.prio     = pts_pkg::PRIO_W'(p);
    it.slice    = pts_pkg::SLICE_W'(sl);
    it.runnable = r;
    return it;
  endfunction

  function automatic pts_pkg::pts_in_t tick_cmd();
    pts_pkg::pts_in_t it;
    it      = pts_pkg::pts_in_t'($urandom);
    it.func = pts_pkg::FUNC_TICK;
    return it;
  endfunction

  function automatic pts_pkg::pts_out_t sched_res(input int s, input bit sw, input int c,
                                                  input bit rf);
    pts_pkg::pts_out_t res;
    res.current_slot  = pts_pkg::SLOT_W'(s);
    res.switched      = sw;
    res.current_count = pts_pkg::CNT_W'(c);
    res.refilled      = rf;
    return res;
  endfunction

  function automatic void add_row(input pts_pkg::pts_in_t it, input bit typed,
                                  input pts_pkg::pts_out_t res);
    stim_row_t row;
    row.item  = it;
    row.typed = typed;
    row.res   = res;
    stim_table.push_back(row);
  endfunction

  function automatic pts_pkg::pts_in_t random_cmd();
    pts_pkg::pts_in_t it;
    if ($urandom_range(0, 99) < 40) begin
      it.func     = pts_pkg::FUNC_LOAD;
      it.slot     = pts_pkg::SLOT_W'($urandom_range(0, pts_pkg::TASK_SLOTS - 1));
      it.prio     = ($urandom_range(0, 9) != 0) ? pts_pkg::PRIO_W'($urandom_range(1, 8))
                                                : pts_pkg::PRIO_W'($urandom_range(0, 255));
      it.slice    = ($urandom_range(0, 4) != 0) ? pts_pkg::SLICE_W'($urandom_range(0, 7))
                                                : pts_pkg::SLICE_W'($urandom_range(0, 255));
      it.runnable = ($urandom_range(0, 3) != 0);
    end else begin
      it = tick_cmd();
    end
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Holds start until the transfer happens, then records what should come back.
  task automatic issue(input pts_pkg::pts_in_t it, input bit typed,
                       input pts_pkg::pts_out_t typed_res);
    pts_pkg::pts_out_t res;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    res = predict_schedule(it);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // The block must ignore whatever sits on in_item while start is low.
  task automatic hold_off(input int n);
    if (n > 0) begin
      @(negedge clk);
      start   <= 1'b0;
      in_item <= pts_pkg::pts_in_t'($urandom);
      repeat (n - 1) begin
        @(negedge clk);
        in_item <= pts_pkg::pts_in_t'($urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    pts_pkg::pts_out_t exp_res;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_result));
      end else begin
        exp_res = pending_results.pop_front();
        if (out_result.current_slot !== exp_res.current_slot)
          report_mismatch($sformatf("current_slot got %0d exp %0d",
                                    out_result.current_slot, exp_res.current_slot));
        if (out_result.switched !== exp_res.switched)
          report_mismatch($sformatf("switched got %0b exp %0b",
                                    out_result.switched, exp_res.switched));
        if (out_result.current_count !== exp_res.current_count)
          report_mismatch($sformatf("current_count got %0d exp %0d",
                                    out_result.current_count, exp_res.current_count));
        if (out_result.refilled !== exp_res.refilled)
          report_mismatch($sformatf("refilled got %0b exp %0b",
                                    out_result.refilled, exp_res.refilled));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    bit burst;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    mismatch_cnt = 0;
    burst        = 1'b0;
    for (int i = 0; i < pts_pkg::TASK_SLOTS; i++) begin
      shadow_count[i] = '0;
      shadow_prio[i]  = '0;
      shadow_run[i]   = 1'b0;
    end
    shadow_cur = '0;

    // Directed sequence: idle start, slot 0 handling, refill, idle-task rules and ties.
    add_row(tick_cmd(),                 1'b1, sched_res(0, 0, 0, 0));
    add_row(load_cmd(0, 255, 255, 1),   1'b1, sched_res(0, 0, 0, 0));
    add_row(tick_cmd(),                 1'b1, sched_res(0, 0, 0, 0));
    add_row(load_cmd(15, 1, 0, 1),      1'b1, sched_res(0, 0, 0, 0));
    add_row(tick_cmd(),                 1'b1, sched_res(15, 1, 1, 1));
    add_row(tick_cmd(),                 1'b1, sched_res(15, 0, 1, 1));
    add_row(load_cmd(1, 255, 255, 1),   1'b0, '0);
    add_row(tick_cmd(),                 1'b0, '0);
    // The running task is descheduled by its flag but still counts down.
    add_row(load_cmd(1, 255, 2, 0),     1'b0, '0);
    add_row(tick_cmd(),                 1'b0, '0);
    add_row(tick_cmd(),                 1'b0, '0);
    // Zero priority keeps the counter at zero even after a refill.
    add_row(load_cmd(15, 0, 0, 1),      1'b0, '0);
    add_row(tick_cmd(),                 1'b0, '0);
    add_row(load_cmd(15, 0, 0, 0),      1'b0, '0);
    add_row(tick_cmd(),                 1'b0, '0);
    add_row(load_cmd(3, 255, 255, 1),   1'b0, '0);
    add_row(load_cmd(9, 255, 255, 1),   1'b0, '0);
    add_row(tick_cmd(),                 1'b0, '0);
    add_row(load_cmd(9, 1, 0, 0),       1'b0, '0);
    add_row(tick_cmd(),                 1'b0, '0);
    add_row(load_cmd(2, 128, 127, 1),   1'b0, '0);
    add_row(load_cmd(0, 0, 0, 0),       1'b0, '0);
    add_row(tick_cmd(),                 1'b0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      issue(stim_table[i].item, stim_table[i].typed, stim_table[i].res);
      hold_off(pick_gap());
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0)
        burst = ($urandom_range(0, 2) == 0);
      if (n % 500 == 250) begin
        // Let the block drain completely before the next transfer.
        hold_off(1);
        while (pending_results.size() != 0) @(posedge clk);
      end
      issue(random_cmd(), 1'b0, '0);
      if (!burst)
        hold_off(pick_gap());
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
